### design/lru_kv_pkg.sv
`timescale 1ns / 1ps
package lru_kv_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // broadcast from the control to every cell
  typedef struct packed {
    logic promote;  // accepted item hit: move matching entry to the head
    logic insert;   // accepted put missed: push a new entry at the head
    logic evict;    // store full: the tail entry drops off on insert
  } ctrl_t;

endpackage

### design/lru_kv_cell.sv
`timescale 1ns / 1ps
module lru_kv_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lru_kv_pkg::ctrl_t          ctrl_i,
  input  logic [lru_kv_pkg::KEY_W-1:0] lookup_key_i,
  // entry of the neighbor one place more recent (the new head for cell 0)
  input  logic [lru_kv_pkg::KEY_W-1:0] prev_key_i,
  input  logic [lru_kv_pkg::VAL_W-1:0] prev_value_i,
  input  logic                       prev_valid_i,
  // lookup chain
  input  logic                       found_above_i,
  input  logic [lru_kv_pkg::VAL_W-1:0] rd_above_i,
  output logic                       found_below_o,
  output logic [lru_kv_pkg::VAL_W-1:0] rd_below_o,
  // this cell's entry, handed to the next cell
  output logic [lru_kv_pkg::KEY_W-1:0] key_o,
  output logic [lru_kv_pkg::VAL_W-1:0] value_o,
  output logic                       valid_o
);
  import lru_kv_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             valid_q;
  logic             match;
  logic             shift;

  assign match = valid_q && (key_q == lookup_key_i);

  assign found_below_o = found_above_i | match;
  assign rd_below_o    = rd_above_i | (match ? value_q : '0);

  // on a hit every cell from the head down to the match takes its neighbor
  always_comb begin
    shift = 1'b0;
    if (ctrl_i.promote) begin
      shift = !found_above_i;
    end else if (ctrl_i.insert) begin
      shift = ctrl_i.evict ? valid_q : prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

### design/lru_key_value_cache.sv
`timescale 1ns / 1ps
// channel  | valid / ready            | payload
// ---------+--------------------------+------------------------------
// input    | in_valid_i / in_ready_o   | op_i, key_i, data_in_i
// output   | out_valid_o / out_ready_i | hit_o, data_out_o
// config   | cfg_valid_i / cfg_ready_o | cfg_data_i (capacity)
//
// one item per cycle unless held off: lookup across the cell row and the shift of
// the row happen in the accepting cycle; a get result appears in the next cycle.
// entries sit in recency order, cell 0 most recent; the tail is the eviction victim.
// reset clears all valid bits, the fill count and the output valid flag.
// input is held off only while a get result waits and the output is stalled.
module lru_key_value_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [lru_kv_pkg::KEY_W-1:0]   key_i,
  input  logic [lru_kv_pkg::VAL_W-1:0]   data_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [lru_kv_pkg::VAL_W-1:0]   data_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lru_kv_pkg::CAP_W-1:0]   cfg_data_i
);
  import lru_kv_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] eff_cap;
  logic             out_valid_q;
  logic             hit_q;
  logic [VAL_W-1:0] data_out_q;

  logic             accept;
  logic             hit;
  logic [VAL_W-1:0] hit_value;
  ctrl_t            ctrl;
  logic [KEY_W-1:0] head_key;
  logic [VAL_W-1:0] head_value;

  logic [KEY_W-1:0] cell_key   [ENTRIES+1];
  logic [VAL_W-1:0] cell_value [ENTRIES+1];
  logic             cell_valid [ENTRIES+1];
  logic             found      [ENTRIES+1];
  logic [VAL_W-1:0] rd         [ENTRIES+1];

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // capacity 0 acts as 1, anything above the row length as the row length
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > 32'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign hit       = found[ENTRIES];
  assign hit_value = rd[ENTRIES];

  assign ctrl.promote = accept && hit;
  assign ctrl.insert  = accept && (op_i == OP_PUT) && !hit;
  assign ctrl.evict   = fill_q >= eff_cap;

  assign head_key   = key_i;
  assign head_value = (op_i == OP_PUT) ? data_in_i : hit_value;

  assign cell_key[0]   = head_key;
  assign cell_value[0] = head_value;
  assign cell_valid[0] = 1'b1;
  assign found[0]      = 1'b0;
  assign rd[0]         = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lru_kv_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .lookup_key_i  (key_i),
      .prev_key_i    (cell_key[g]),
      .prev_value_i  (cell_value[g]),
      .prev_valid_i  (cell_valid[g]),
      .found_above_i (found[g]),
      .rd_above_i    (rd[g]),
      .found_below_o (found[g+1]),
      .rd_below_o    (rd[g+1]),
      .key_o         (cell_key[g+1]),
      .value_o       (cell_value[g+1]),
      .valid_o       (cell_valid[g+1])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl.insert && !ctrl.evict) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      if (accept && (op_i == OP_GET)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (op_i == OP_GET)) begin
      hit_q      <= hit;
      data_out_q <= hit ? hit_value : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign data_out_o  = data_out_q;

endmodule
